@@ rtl/alpha_blend_8bit_pixel_unit_defines.svh @@
// Assertion helpers for the alpha blend unit.
// Both forms sample on clk and are switched off while arst_n is low.
`ifndef ALPHA_BLEND_8BIT_PIXEL_UNIT_DEFINES_SVH
`define ALPHA_BLEND_8BIT_PIXEL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AB8_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AB8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ab8_pkg.sv @@
`timescale 1ns / 1ps

package ab8_pkg;

	typedef logic [7:0] pix_t;

	localparam int COMP_W    = 3;
	localparam int OPACITY_W = 17;
	localparam int IDX_W     = 2;
	localparam int LANES     = 3;

	typedef logic [COMP_W-1:0]    comp_t;
	typedef logic [OPACITY_W-1:0] opacity_t;
	typedef logic [IDX_W-1:0]     reg_idx_t;

	// Configuration register indexes.
	localparam reg_idx_t REG_SRC_COMP  = 2'd0;
	localparam reg_idx_t REG_DEST_COMP = 2'd1;
	localparam reg_idx_t REG_OPACITY   = 2'd2;

	localparam comp_t    COMP_LUM      = 3'd1;
	localparam comp_t    COMP_LUM_A    = 3'd2;
	localparam comp_t    COMP_RGB      = 3'd3;
	localparam comp_t    COMP_RGBA     = 3'd4;
	localparam opacity_t OPAQUE        = 17'h10000;
	localparam pix_t     PIX_MAX       = 8'd255;

	// Per-channel blend enables.
	localparam logic [LANES-1:0] MASK_NONE = 3'b000;
	localparam logic [LANES-1:0] MASK_LUM  = 3'b001;
	localparam logic [LANES-1:0] MASK_RGB  = 3'b111;

	// Control handed from the weight stage to the lanes and merge stage.
	typedef struct packed {
		logic [LANES-1:0] mask;
		pix_t             weight;
	} ctrl_t;

endpackage

@@ rtl/alpha_blend_8bit_pixel_unit.sv @@
`timescale 1ns / 1ps
`include "alpha_blend_8bit_pixel_unit_defines.svh"

// Blends one source pixel over one 8-bit destination pixel per clock while the
// output is not stalled. A request is taken in every cycle that in_stall is low and
// moves through the stages in turn: the first stage forms the weight with one 8 x 17
// multiply of alpha by the layer opacity, the second runs three channel lanes side by
// side and merges their results with the untouched destination channels into the
// output register. A new request is accepted whenever the first stage is empty or can
// move on, so a result waiting on out_stall does not block the input while a slot is
// free. Configuration registers are written with no wait states.
module alpha_blend_8bit_pixel_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  ab8_pkg::reg_idx_t cfg_index,
	input  ab8_pkg::opacity_t cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  ab8_pkg::pix_t     dest_ch0,
	input  ab8_pkg::pix_t     dest_ch1,
	input  ab8_pkg::pix_t     dest_ch2,
	input  ab8_pkg::pix_t     dest_ch3,
	input  ab8_pkg::pix_t     src_ch0,
	input  ab8_pkg::pix_t     src_ch1,
	input  ab8_pkg::pix_t     src_ch2,
	input  ab8_pkg::pix_t     src_ch3,
	input  logic              inside_stencil,
	output logic              out_valid,
	input  logic              out_stall,
	output ab8_pkg::pix_t     out_ch0,
	output ab8_pkg::pix_t     out_ch1,
	output ab8_pkg::pix_t     out_ch2,
	output ab8_pkg::pix_t     out_ch3
);

	ab8_pkg::comp_t                     src_comp_q;
	ab8_pkg::comp_t                     dest_comp_q;
	ab8_pkg::opacity_t                  opacity_q;

	logic                               valid_s1;
	logic                               valid_s2;
	logic                               ready_s1;
	logic                               ready_s2;
	logic                               load_s1;
	ab8_pkg::ctrl_t                     ctrl_s1;
	ab8_pkg::pix_t [ab8_pkg::LANES-1:0] lane_src_s1;
	ab8_pkg::pix_t [3:0]                dst_s1;
	ab8_pkg::pix_t [ab8_pkg::LANES-1:0] mixed;
	ab8_pkg::pix_t [3:0]                out_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_comp_q  <= ab8_pkg::COMP_LUM;
			dest_comp_q <= ab8_pkg::COMP_LUM;
			opacity_q   <= ab8_pkg::OPAQUE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ab8_pkg::REG_SRC_COMP:  src_comp_q  <= cfg_data[ab8_pkg::COMP_W-1:0];
				ab8_pkg::REG_DEST_COMP: dest_comp_q <= cfg_data[ab8_pkg::COMP_W-1:0];
				ab8_pkg::REG_OPACITY:   opacity_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage moves on when the stage after it is empty or draining.
	assign ready_s2 = !valid_s2 || !out_stall;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign load_s1  = in_valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	ab8_weight u_weight (
		.clk         (clk),
		.en          (load_s1),
		.src_comp    (src_comp_q),
		.dest_comp   (dest_comp_q),
		.opacity     (opacity_q),
		.src_ch0     (src_ch0),
		.src_ch1     (src_ch1),
		.src_ch2     (src_ch2),
		.src_ch3     (src_ch3),
		.stencil     (inside_stencil),
		.ctrl_s1     (ctrl_s1),
		.lane_src_s1 (lane_src_s1)
	);

	always_ff @(posedge clk) begin
		if (load_s1) begin
			dst_s1 <= {dest_ch3, dest_ch2, dest_ch1, dest_ch0};
		end
	end

	for (genvar i = 0; i < ab8_pkg::LANES; i++) begin : g_lane
		ab8_lane u_lane (
			.dst    (dst_s1[i]),
			.src    (lane_src_s1[i]),
			.weight (ctrl_s1.weight),
			.mixed  (mixed[i])
		);
	end

	// Merge: channels outside the blend mask, and alpha, keep the destination.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			for (int i = 0; i < ab8_pkg::LANES; i++) begin
				out_s2[i] <= ctrl_s1.mask[i] ? mixed[i] : dst_s1[i];
			end
			out_s2[3] <= dst_s1[3];
		end
	end

	assign out_valid = valid_s2;
	assign out_ch0   = out_s2[0];
	assign out_ch1   = out_s2[1];
	assign out_ch2   = out_s2[2];
	assign out_ch3   = out_s2[3];

	`AB8_ASSERT_SAME(a_free_slot_accepts, !valid_s1, !in_stall, "input stalled with stage one empty")
	`AB8_ASSERT_SAME(a_mask_legal, valid_s1, (ctrl_s1.mask == ab8_pkg::MASK_NONE) || (ctrl_s1.mask == ab8_pkg::MASK_LUM) || (ctrl_s1.mask == ab8_pkg::MASK_RGB), "illegal blend mask")
	`AB8_ASSERT_NEXT(a_unmasked_keeps_dest, valid_s1 && ready_s2 && (ctrl_s1.mask == ab8_pkg::MASK_NONE), out_ch0 == $past(dst_s1[0]), "pixel outside stencil changed channel 0")
	`AB8_ASSERT_NEXT(a_alpha_passes, valid_s1 && ready_s2, out_ch3 == $past(dst_s1[3]), "alpha channel not passed through")

endmodule

@@ rtl/ab8_weight.sv @@
`timescale 1ns / 1ps

module ab8_weight (
	input  logic                              clk,
	input  logic                              en,
	input  ab8_pkg::comp_t                    src_comp,
	input  ab8_pkg::comp_t                    dest_comp,
	input  ab8_pkg::opacity_t                 opacity,
	input  ab8_pkg::pix_t                     src_ch0,
	input  ab8_pkg::pix_t                     src_ch1,
	input  ab8_pkg::pix_t                     src_ch2,
	input  ab8_pkg::pix_t                     src_ch3,
	input  logic                              stencil,
	output ab8_pkg::ctrl_t                    ctrl_s1,
	output ab8_pkg::pix_t [ab8_pkg::LANES-1:0] lane_src_s1
);

	logic                                colour;
	logic                                src_rgba;
	ab8_pkg::pix_t                       alpha;
	ab8_pkg::opacity_t                   op_sat;
	logic [24:0]                         prod;
	ab8_pkg::ctrl_t                      ctrl_d;
	ab8_pkg::pix_t [ab8_pkg::LANES-1:0]  src_d;

	always_comb begin
		colour   = (dest_comp >= ab8_pkg::COMP_RGB);
		src_rgba = (src_comp >= ab8_pkg::COMP_RGBA);
		op_sat   = (opacity > ab8_pkg::OPAQUE) ? ab8_pkg::OPAQUE : opacity;

		if (colour && src_rgba) begin
			alpha = src_ch3;
		end else if (src_comp == ab8_pkg::COMP_LUM_A) begin
			alpha = src_ch1;
		end else begin
			alpha = ab8_pkg::PIX_MAX;
		end

		prod = 25'(alpha) * 25'(op_sat);
		ctrl_d.weight = prod[23:16];

		// A zero source count on a colour destination blends only channel 0.
		if (!stencil) begin
			ctrl_d.mask = ab8_pkg::MASK_NONE;
		end else if (colour && (src_comp != 3'd0)) begin
			ctrl_d.mask = ab8_pkg::MASK_RGB;
		end else begin
			ctrl_d.mask = ab8_pkg::MASK_LUM;
		end

		// A luminance source feeds all three colour lanes.
		src_d[0] = src_ch0;
		if (colour && (src_comp >= ab8_pkg::COMP_RGB)) begin
			src_d[1] = src_ch1;
			src_d[2] = src_ch2;
		end else begin
			src_d[1] = src_ch0;
			src_d[2] = src_ch0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1     <= ctrl_d;
			lane_src_s1 <= src_d;
		end
	end

endmodule

@@ rtl/ab8_lane.sv @@
`timescale 1ns / 1ps

module ab8_lane (
	input  ab8_pkg::pix_t dst,
	input  ab8_pkg::pix_t src,
	input  ab8_pkg::pix_t weight,
	output ab8_pkg::pix_t mixed
);

	ab8_pkg::pix_t inv;
	logic [15:0]   sum;

	// The largest sum is 255 * 255, so 16 bits hold it.
	always_comb begin
		inv   = ab8_pkg::PIX_MAX - weight;
		sum   = 16'(dst) * 16'(inv) + 16'(src) * 16'(weight);
		mixed = sum[15:8];
	end

endmodule

@@ sim/tb_alpha_blend_8bit_pixel_unit.sv @@
`timescale 1ns / 1ps

module tb_alpha_blend_8bit_pixel_unit;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 14;
	localparam int RANDOM_RUN  = 57;

	typedef logic [3:0][7:0] quad_t;

	typedef struct packed {
		quad_t dst;
		quad_t src;
		logic  stencil;
	} pixel_req_t;

	typedef enum int {
		MODE_RGBA, MODE_RGB, MODE_LUMA_COLOR, MODE_LUM_COLOR,
		MODE_LUMA_GREY, MODE_LUM_GREY, MODE_PASS
	} blend_mode_t;

	class pixel_blend_scoreboard;
		ab8_pkg::comp_t    src_comp;
		ab8_pkg::comp_t    dst_comp;
		ab8_pkg::opacity_t opacity;
		quad_t             blended_pixels [$];
		int                n_checked;
		int                n_errors;
		int                mode_hits [7];

		function new();
			src_comp  = ab8_pkg::COMP_LUM;
			dst_comp  = ab8_pkg::COMP_LUM;
			opacity   = ab8_pkg::OPAQUE;
			n_checked = 0;
			n_errors  = 0;
			foreach (mode_hits[m]) mode_hits[m] = 0;
		endfunction

		// Weight r = (alpha * opacity) >> 16, then each blended lane is
		// (dst * (255 - r) + src * r) >> 8.
		function quad_t blend_over(pixel_req_t p);
			quad_t       o;
			int unsigned op;
			int unsigned alpha;
			int unsigned r;
			int unsigned s;
			int          lanes;
			bit          per_lane;
			bit          color;
			blend_mode_t mode;
			o = p.dst;
			if (!p.stencil) begin
				mode_hits[MODE_PASS]++;
				return o;
			end
			op = (opacity > ab8_pkg::OPAQUE) ? ab8_pkg::OPAQUE : opacity;
			color = (dst_comp >= ab8_pkg::COMP_RGB);
			lanes = 1;
			per_lane = 1'b0;
			alpha = ab8_pkg::PIX_MAX;
			if (color && src_comp >= ab8_pkg::COMP_RGBA) begin
				mode = MODE_RGBA;
				alpha = p.src[3];
				lanes = 3;
				per_lane = 1'b1;
			end else if (color && src_comp == ab8_pkg::COMP_RGB) begin
				mode = MODE_RGB;
				lanes = 3;
				per_lane = 1'b1;
			end else if (color && src_comp == ab8_pkg::COMP_LUM_A) begin
				mode = MODE_LUMA_COLOR;
				alpha = p.src[1];
				lanes = 3;
			end else if (color && src_comp == ab8_pkg::COMP_LUM) begin
				mode = MODE_LUM_COLOR;
				lanes = 3;
			end else if (src_comp == ab8_pkg::COMP_LUM_A) begin
				mode = MODE_LUMA_GREY;
				alpha = p.src[1];
			end else begin
				// Zero components, or a luminance or color source on a grey destination.
				mode = MODE_LUM_GREY;
			end
			mode_hits[mode]++;
			r = (alpha * op) >> 16;
			for (int c = 0; c < lanes; c++) begin
				s = per_lane ? p.src[c] : p.src[0];
				o[c] = 8'((p.dst[c] * (255 - r) + s * r) >> 8);
			end
			return o;
		endfunction

		function void note_request(pixel_req_t p);
			blended_pixels.push_back(blend_over(p));
		endfunction

		function int pending();
			return blended_pixels.size();
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			n_errors++;
		endtask

		task check_result(quad_t got);
			quad_t want;
			if (blended_pixels.size() == 0) begin
				report($sformatf("result %h arrived with no request pending", got));
				return;
			end
			want = blended_pixels.pop_front();
			for (int c = 0; c < 4; c++) begin
				if (got[c] !== want[c])
					report($sformatf("result %0d out_ch%0d: got %0d, expected %0d",
						n_checked, c, got[c], want[c]));
			end
			n_checked++;
		endtask
	endclass

	logic              clk;
	logic              arst_n         = 1'b0;
	logic              cfg_valid      = 1'b0;
	logic              cfg_ready;
	ab8_pkg::reg_idx_t cfg_index      = ab8_pkg::REG_SRC_COMP;
	ab8_pkg::opacity_t cfg_data       = '0;
	logic              in_valid       = 1'b0;
	logic              in_stall;
	ab8_pkg::pix_t     dest_ch0       = '0;
	ab8_pkg::pix_t     dest_ch1       = '0;
	ab8_pkg::pix_t     dest_ch2       = '0;
	ab8_pkg::pix_t     dest_ch3       = '0;
	ab8_pkg::pix_t     src_ch0        = '0;
	ab8_pkg::pix_t     src_ch1        = '0;
	ab8_pkg::pix_t     src_ch2        = '0;
	ab8_pkg::pix_t     src_ch3        = '0;
	logic              inside_stencil = 1'b0;
	logic              out_valid;
	logic              out_stall      = 1'b0;
	ab8_pkg::pix_t     out_ch0;
	ab8_pkg::pix_t     out_ch1;
	ab8_pkg::pix_t     out_ch2;
	ab8_pkg::pix_t     out_ch3;

	int cycle_count = 0;
	int stall_hold  = 0;
	int n_requests  = 0;
	int n_settings  = 1;

	pixel_blend_scoreboard sb;

	alpha_blend_8bit_pixel_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.dest_ch0       (dest_ch0),
		.dest_ch1       (dest_ch1),
		.dest_ch2       (dest_ch2),
		.dest_ch3       (dest_ch3),
		.src_ch0        (src_ch0),
		.src_ch1        (src_ch1),
		.src_ch2        (src_ch2),
		.src_ch3        (src_ch3),
		.inside_stencil (inside_stencil),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_ch0        (out_ch0),
		.out_ch1        (out_ch1),
		.out_ch2        (out_ch2),
		.out_ch3        (out_ch3)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Timed out after %0d cycles", cycle_count);
		$display("[alpha_blend_8bit_pixel_unit] ERROR");
		$finish;
	end

	// Outputs are sampled right after the edge, before any register update.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({out_ch3, out_ch2, out_ch1, out_ch0});
	end

	// Receiver back-pressure: random stretches of no stall, light stall, heavy
	// stall and toggling, overridden by a long hold-off when one is requested.
	initial begin
		int left;
		int mode;
		left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (stall_hold > 0) begin
				out_stall <= 1'b1;
				stall_hold--;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(4, 50);
				end
				left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	task automatic write_reg(input ab8_pkg::reg_idx_t idx, input ab8_pkg::opacity_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ab8_pkg::REG_SRC_COMP:  sb.src_comp = val[ab8_pkg::COMP_W-1:0];
			ab8_pkg::REG_DEST_COMP: sb.dst_comp = val[ab8_pkg::COMP_W-1:0];
			ab8_pkg::REG_OPACITY:   sb.opacity  = val;
			default: ;
		endcase
	endtask

	task automatic configure(input ab8_pkg::comp_t src_c, input ab8_pkg::comp_t dst_c,
		input ab8_pkg::opacity_t op);
		write_reg(ab8_pkg::REG_SRC_COMP, ab8_pkg::opacity_t'(src_c));
		write_reg(ab8_pkg::REG_DEST_COMP, ab8_pkg::opacity_t'(dst_c));
		write_reg(ab8_pkg::REG_OPACITY, op);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Stop sending, let every blended pixel come back, then let the bench idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_pixel(input pixel_req_t p);
		in_valid <= 1'b1;
		{dest_ch3, dest_ch2, dest_ch1, dest_ch0} <= p.dst;
		{src_ch3, src_ch2, src_ch1, src_ch0}     <= p.src;
		inside_stencil <= p.stencil;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(p);
		n_requests++;
	endtask

	function automatic pixel_req_t random_pixel();
		pixel_req_t p;
		for (int c = 0; c < 4; c++) begin
			p.dst[c] = 8'($urandom_range(0, 255));
			p.src[c] = 8'($urandom_range(0, 255));
		end
		// Push the alpha channels to their extremes now and then.
		if ($urandom_range(0, 7) == 0)
			p.src[3] = $urandom_range(0, 1) ? ab8_pkg::PIX_MAX : 8'd0;
		if ($urandom_range(0, 7) == 0)
			p.src[1] = $urandom_range(0, 1) ? ab8_pkg::PIX_MAX : 8'd0;
		p.stencil = ($urandom_range(0, 7) != 0);
		return p;
	endfunction

	function automatic pixel_req_t corner_pixel(input int k);
		pixel_req_t p;
		p = random_pixel();
		p.stencil = 1'b1;
		case (k)
			0: begin
				p.dst = '0;
				p.src = '0;
			end
			1: begin
				p.dst = '1;
				p.src = '1;
			end
			2: begin
				p.dst = '1;
				p.src = {ab8_pkg::PIX_MAX, 8'd0, ab8_pkg::PIX_MAX, 8'd0};
			end
			3: begin
				p.dst = '0;
				p.src = {8'd0, ab8_pkg::PIX_MAX, 8'd0, ab8_pkg::PIX_MAX};
			end
			default: p.stencil = 1'b0;
		endcase
		return p;
	endfunction

	task automatic random_run(input int count, input bit bursty);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 24);
		for (int i = 0; i < count; i++) begin
			if (bursty && burst_left == 0) begin
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			push_pixel(random_pixel());
			burst_left--;
		end
	endtask

	function automatic ab8_pkg::opacity_t random_opacity();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ab8_pkg::OPAQUE;
			default: return ab8_pkg::opacity_t'($urandom_range(0, 131071));
		endcase
	endfunction

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1:  configure(ab8_pkg::COMP_RGBA, ab8_pkg::COMP_RGBA, ab8_pkg::OPAQUE);
					2:  configure(ab8_pkg::COMP_RGB, ab8_pkg::COMP_RGB, '0);
					3:  configure(ab8_pkg::COMP_LUM_A, ab8_pkg::COMP_RGBA, 17'd32768);
					4:  configure(ab8_pkg::COMP_LUM, ab8_pkg::COMP_RGB, 17'd65535);
					5:  configure(ab8_pkg::COMP_LUM_A, ab8_pkg::COMP_LUM_A, ab8_pkg::OPAQUE);
					6:  configure(ab8_pkg::COMP_RGB, ab8_pkg::COMP_LUM, 17'd1);
					7:  configure(3'd0, ab8_pkg::COMP_RGBA, random_opacity());
					8:  configure(3'd6, ab8_pkg::COMP_RGB, 17'h1FFFF);
					9:  configure(ab8_pkg::COMP_RGBA, 3'd0, 17'd70000);
					10: configure(3'd7, 3'd7, random_opacity());
					default: configure(ab8_pkg::comp_t'($urandom_range(0, 7)),
						ab8_pkg::comp_t'($urandom_range(0, 7)), random_opacity());
				endcase
			end
			if (ph < 8) begin
				for (int j = 0; j < 3; j++)
					push_pixel(corner_pixel((ph + j) % 5));
			end
			if (ph == 3) begin
				// Long receiver hold-off under a steady request stream.
				stall_hold = 80;
				random_run(40, 1'b0);
			end
			random_run(RANDOM_RUN, (ph % 4) != 1);
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Blended %0d pixel requests under %0d register settings, %0d results checked.",
			n_requests, n_settings, sb.n_checked);
		$display("Mode hits rgba %0d rgb %0d lum+a/color %0d lum/color %0d",
			sb.mode_hits[MODE_RGBA], sb.mode_hits[MODE_RGB],
			sb.mode_hits[MODE_LUMA_COLOR], sb.mode_hits[MODE_LUM_COLOR]);
		$display("Mode hits lum+a/grey %0d lum/grey %0d outside stencil %0d",
			sb.mode_hits[MODE_LUMA_GREY], sb.mode_hits[MODE_LUM_GREY],
			sb.mode_hits[MODE_PASS]);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("[alpha_blend_8bit_pixel_unit] OK");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.n_errors, sb.pending());
			$display("[alpha_blend_8bit_pixel_unit] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ab8_pkg.sv
rtl/ab8_weight.sv
rtl/ab8_lane.sv
rtl/alpha_blend_8bit_pixel_unit.sv
sim/tb_alpha_blend_8bit_pixel_unit.sv
